[hdl/dmac_pkg.sv]
`timescale 1ns / 1ps
// Shared types and constants for the dual moving average crossover core.
// No dependencies; imported by every module of the block.
package dmac_pkg;

  localparam int MAX_WINDOW = 1024;
  localparam int PRICE_W    = 32;
  localparam int WIN_W      = $clog2(MAX_WINDOW) + 1;
  localparam int RING_AW    = $clog2(MAX_WINDOW);
  localparam int SUM_W      = PRICE_W + RING_AW;
  localparam int SUMX_W     = SUM_W + 1;
  localparam int DIVR_W     = PRICE_W + 1;
  localparam int DIVQ_W     = PRICE_W + 2;
  localparam int PROD_W     = 2 * PRICE_W;
  localparam int LVL_W      = PRICE_W + 4;
  localparam int PAIR_W     = 5;
  localparam int CFG_IDX_W  = 2;

  localparam logic [WIN_W-1:0]  WIN_MAX       = WIN_W'(MAX_WINDOW);
  localparam logic [WIN_W-1:0]  CNT_MAX       = WIN_W'(MAX_WINDOW + 1);
  localparam logic [WIN_W-1:0]  WIN_SHORT_RST = WIN_W'(13);
  localparam logic [WIN_W-1:0]  WIN_LONG_RST  = WIN_W'(30);
  localparam logic [PAIR_W-1:0] AVG_PAIRS     = PAIR_W'(PRICE_W / 2);
  localparam logic [PAIR_W-1:0] CROSS_PAIRS   = PAIR_W'(DIVQ_W / 2);

  localparam logic [CFG_IDX_W-1:0] REG_WIN_SHORT = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] REG_WIN_LONG  = CFG_IDX_W'(1);

  typedef enum logic [1:0] {
    CROSS_NONE = 2'd0,
    CROSS_UP   = 2'd1,
    CROSS_DOWN = 2'd2
  } cross_t;

  typedef enum logic [1:0] {
    SEL_SHORT = 2'd0,
    SEL_LONG  = 2'd1,
    SEL_CROSS = 2'd2
  } div_sel_t;

  typedef struct packed {
    logic     accept;
    logic     sum_upd;
    logic     div_start;
    div_sel_t div_sel;
    logic     cap_s;
    logic     cap_l;
    logic     diff;
    logic     mul;
    logic     check;
    logic     load_out;
  } cmd_t;

endpackage

[hdl/dmac_div.sv]
`timescale 1ns / 1ps
// Iterative restoring divider, two quotient bits per cycle.
// Depends on dmac_pkg.
module dmac_div (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           start,
  input  logic [dmac_pkg::DIVR_W-1:0]    divisor,
  input  logic [dmac_pkg::DIVR_W-1:0]    rem_init,
  input  logic [dmac_pkg::DIVQ_W-1:0]    low,
  input  logic [dmac_pkg::PAIR_W-1:0]    pairs,
  output logic                           done,
  output logic [dmac_pkg::DIVQ_W-1:0]    quot,
  output logic                           rem_nz
);
  import dmac_pkg::*;

  logic [DIVR_W-1:0] rem_r, rem_nxt;
  logic [DIVR_W-1:0] div_r;
  logic [DIVQ_W-1:0] low_r;
  logic [DIVQ_W-1:0] q_r;
  logic [1:0]        qb;
  logic [PAIR_W-1:0] cnt_r;
  logic              busy_r;
  logic              done_r;

  always_comb begin
    logic [DIVR_W:0] r2;
    r2      = '0;
    rem_nxt = rem_r;
    qb      = '0;
    for (int i = 0; i < 2; i++) begin
      r2 = {rem_nxt, low_r[DIVQ_W-1-i]};
      if (r2 >= {1'b0, div_r}) begin
        r2        = r2 - {1'b0, div_r};
        qb[1-i]   = 1'b1;
      end
      rem_nxt = r2[DIVR_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem_r <= rem_init;
      div_r <= divisor;
      low_r <= low;
      q_r   <= '0;
    end else if (busy_r) begin
      rem_r <= rem_nxt;
      low_r <= {low_r[DIVQ_W-3:0], 2'b00};
      q_r   <= {q_r[DIVQ_W-3:0], qb};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else if (start) begin
      busy_r <= 1'b1;
      done_r <= 1'b0;
      cnt_r  <= pairs;
    end else if (busy_r) begin
      cnt_r  <= cnt_r - 1'b1;
      busy_r <= (cnt_r != PAIR_W'(1));
      done_r <= (cnt_r == PAIR_W'(1));
    end else begin
      done_r <= 1'b0;
    end
  end

  assign done   = done_r;
  assign quot   = q_r;
  assign rem_nz = (rem_r != '0);

endmodule

[hdl/dmac_datapath.sv]
`timescale 1ns / 1ps
// Datapath: price ring, running sums, averages, crossover level, result register.
// Depends on dmac_pkg and dmac_div; driven by dmac_ctrl commands.
module dmac_datapath (
  input  logic                               clk,
  input  logic                               rst_n,
  input  dmac_pkg::cmd_t                     cmd,
  output logic                               div_done,
  input  logic [dmac_pkg::PRICE_W-1:0]       in_price,
  input  logic                               cfg_we,
  input  logic [dmac_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [dmac_pkg::WIN_W-1:0]         cfg_data,
  output logic [dmac_pkg::PRICE_W-1:0]       out_ma_short,
  output logic [dmac_pkg::PRICE_W-1:0]       out_ma_long,
  output logic [1:0]                         out_cross_code,
  output logic [dmac_pkg::PRICE_W-1:0]       out_cross_level,
  output logic                               out_ready_res
);
  import dmac_pkg::*;

  logic [PRICE_W-1:0] ring_mem [MAX_WINDOW];

  logic [WIN_W-1:0]   ws_r, wl_r;
  logic [RING_AW-1:0] wp_r;
  logic [WIN_W-1:0]   cnt_r;
  logic [SUM_W-1:0]   sum_s_r, sum_l_r;
  logic [PRICE_W-1:0] prev_s_r, prev_l_r;
  logic [PRICE_W-1:0] price_r, rd_s_r, rd_l_r;
  logic [PRICE_W-1:0] ms_r, ml_r;
  logic               first_r, use_p_s_r, use_p_l_r, rdy_r;
  logic [PRICE_W-1:0] mag_ds_r, mag_d_r;
  logic [DIVR_W-1:0]  mag_den_r;
  logic               neg_r, degen_r, big_r;
  cross_t             code_r;
  logic [PROD_W-1:0]  prod_r;

  logic [PRICE_W-1:0] o_ms_r, o_ml_r, o_lvl_r;
  cross_t             o_code_r;
  logic               o_rdy_r;

  logic [RING_AW-1:0] addr_s, addr_l;
  logic               ok_s, ok_l, full_s, full_l;
  logic [SUMX_W-1:0]  sumx_s, sumx_l;
  logic [WIN_W-1:0]   cnt_inc;
  logic               clear;

  logic [DIVR_W-1:0]  d_divisor, d_rem_init;
  logic [DIVQ_W-1:0]  d_low, d_quot;
  logic [PAIR_W-1:0]  d_pairs;
  logic               d_rem_nz;

  logic signed [PRICE_W+1:0] d_s, e_s, den_s, ds_s;
  logic [PRICE_W+1:0]        d_abs, ds_abs, den_abs;
  cross_t                    code_nxt;
  logic [LVL_W-1:0]          lvl_x;
  logic [PRICE_W-1:0]        lvl_nxt;

  assign clear = cfg_we && (cfg_index == REG_WIN_SHORT || cfg_index == REG_WIN_LONG);

  assign addr_s = wp_r - ws_r[RING_AW-1:0];
  assign addr_l = wp_r - wl_r[RING_AW-1:0];

  always_comb begin
    ok_s    = (ws_r != '0) && (ws_r <= WIN_MAX);
    ok_l    = (wl_r != '0) && (wl_r <= WIN_MAX);
    full_s  = (cnt_r >= ws_r);
    full_l  = (cnt_r >= wl_r);
    sumx_s  = {1'b0, sum_s_r} + SUMX_W'(price_r) - (full_s ? SUMX_W'(rd_s_r) : '0);
    sumx_l  = {1'b0, sum_l_r} + SUMX_W'(price_r) - (full_l ? SUMX_W'(rd_l_r) : '0);
    cnt_inc = (cnt_r >= CNT_MAX) ? CNT_MAX : cnt_r + 1'b1;
  end

  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      ring_mem[wp_r] <= in_price;
      rd_s_r         <= ring_mem[addr_s];
      rd_l_r         <= ring_mem[addr_l];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ws_r     <= WIN_SHORT_RST;
      wl_r     <= WIN_LONG_RST;
      wp_r     <= '0;
      cnt_r    <= '0;
      sum_s_r  <= '0;
      sum_l_r  <= '0;
      prev_s_r <= '0;
      prev_l_r <= '0;
    end else if (clear) begin
      if (cfg_index == REG_WIN_SHORT) begin
        ws_r <= cfg_data;
      end else begin
        wl_r <= cfg_data;
      end
      wp_r     <= '0;
      cnt_r    <= '0;
      sum_s_r  <= '0;
      sum_l_r  <= '0;
      prev_s_r <= '0;
      prev_l_r <= '0;
    end else begin
      if (cmd.accept) begin
        wp_r <= wp_r + 1'b1;
      end
      if (cmd.sum_upd) begin
        sum_s_r <= ok_s ? sumx_s[SUM_W-1:0] : '0;
        sum_l_r <= ok_l ? sumx_l[SUM_W-1:0] : '0;
        cnt_r   <= cnt_inc;
      end
      if (cmd.load_out) begin
        prev_s_r <= ms_r;
        prev_l_r <= ml_r;
      end
    end
  end

  // Divider operand select
  always_comb begin
    case (cmd.div_sel)
      SEL_SHORT: begin
        d_divisor  = DIVR_W'(ws_r);
        d_rem_init = DIVR_W'(sum_s_r[SUM_W-1:PRICE_W]);
        d_low      = {sum_s_r[PRICE_W-1:0], 2'b00};
        d_pairs    = AVG_PAIRS;
      end
      SEL_LONG: begin
        d_divisor  = DIVR_W'(wl_r);
        d_rem_init = DIVR_W'(sum_l_r[SUM_W-1:PRICE_W]);
        d_low      = {sum_l_r[PRICE_W-1:0], 2'b00};
        d_pairs    = AVG_PAIRS;
      end
      SEL_CROSS: begin
        d_divisor  = mag_den_r;
        d_rem_init = DIVR_W'(prod_r[PROD_W-1:DIVQ_W]);
        d_low      = prod_r[DIVQ_W-1:0];
        d_pairs    = CROSS_PAIRS;
      end
      default: begin
        d_divisor  = '0;
        d_rem_init = '0;
        d_low      = '0;
        d_pairs    = '0;
      end
    endcase
  end

  dmac_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (cmd.div_start),
    .divisor  (d_divisor),
    .rem_init (d_rem_init),
    .low      (d_low),
    .pairs    (d_pairs),
    .done     (div_done),
    .quot     (d_quot),
    .rem_nz   (d_rem_nz)
  );

  // Crossover differences
  always_comb begin
    d_s     = $signed({2'b00, prev_s_r}) - $signed({2'b00, prev_l_r});
    e_s     = $signed({2'b00, ml_r}) - $signed({2'b00, ms_r});
    den_s   = d_s + e_s;
    ds_s    = $signed({2'b00, ms_r}) - $signed({2'b00, prev_s_r});
    d_abs   = d_s[PRICE_W+1] ? 0 - d_s : d_s;
    ds_abs  = ds_s[PRICE_W+1] ? 0 - ds_s : ds_s;
    den_abs = den_s[PRICE_W+1] ? 0 - den_s : den_s;
    if (prev_s_r < prev_l_r && ml_r < ms_r) begin
      code_nxt = CROSS_UP;
    end else if (prev_s_r > prev_l_r && ml_r > ms_r) begin
      code_nxt = CROSS_DOWN;
    end else begin
      code_nxt = CROSS_NONE;
    end
  end

  // Final level: apply sign, borrow, saturate
  always_comb begin
    if (neg_r) begin
      lvl_x = LVL_W'(prev_s_r) - LVL_W'(d_quot) - LVL_W'(d_rem_nz);
    end else begin
      lvl_x = LVL_W'(prev_s_r) + LVL_W'(d_quot);
    end
    if (first_r) begin
      lvl_nxt = '0;
    end else if (degen_r) begin
      lvl_nxt = prev_s_r;
    end else if (big_r) begin
      lvl_nxt = neg_r ? '0 : '1;
    end else if (lvl_x[LVL_W-1]) begin
      lvl_nxt = '0;
    end else if (lvl_x[LVL_W-2:PRICE_W] != '0) begin
      lvl_nxt = '1;
    end else begin
      lvl_nxt = lvl_x[PRICE_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      price_r <= in_price;
    end
    if (cmd.sum_upd) begin
      first_r   <= (cnt_r == '0);
      use_p_s_r <= (ws_r <= WIN_W'(1)) || (ws_r > WIN_MAX) || (cnt_inc < ws_r);
      use_p_l_r <= (wl_r <= WIN_W'(1)) || (wl_r > WIN_MAX) || (cnt_inc < wl_r);
      rdy_r     <= (cnt_inc > ws_r) && (cnt_inc > wl_r);
    end
    if (cmd.cap_s) begin
      ms_r <= use_p_s_r ? price_r : d_quot[PRICE_W-1:0];
    end
    if (cmd.cap_l) begin
      ml_r <= use_p_l_r ? price_r : d_quot[PRICE_W-1:0];
    end
    if (cmd.diff) begin
      mag_d_r   <= d_abs[PRICE_W-1:0];
      mag_ds_r  <= ds_abs[PRICE_W-1:0];
      mag_den_r <= den_abs[DIVR_W-1:0];
      neg_r     <= (ds_s[PRICE_W+1] ^ d_s[PRICE_W+1]) ^ den_s[PRICE_W+1];
      degen_r   <= (den_s == '0) || (d_s == '0) || (ds_s == '0);
      code_r    <= first_r ? CROSS_NONE : code_nxt;
    end
    if (cmd.mul) begin
      prod_r <= mag_ds_r * mag_d_r;
    end
    if (cmd.check) begin
      big_r <= (DIVR_W'(prod_r[PROD_W-1:PRICE_W+1]) >= mag_den_r);
    end
    if (cmd.load_out) begin
      o_ms_r   <= ms_r;
      o_ml_r   <= ml_r;
      o_code_r <= code_r;
      o_lvl_r  <= lvl_nxt;
      o_rdy_r  <= rdy_r;
    end
  end

  assign out_ma_short    = o_ms_r;
  assign out_ma_long     = o_ml_r;
  assign out_cross_code  = o_code_r;
  assign out_cross_level = o_lvl_r;
  assign out_ready_res   = o_rdy_r;

endmodule

[hdl/dmac_ctrl.sv]
`timescale 1ns / 1ps
// Sequencer: walks one sample through sum update, three divisions and output.
// Depends on dmac_pkg; issues commands to dmac_datapath.
module dmac_ctrl (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           in_valid,
  output logic           in_stall,
  output logic           out_valid,
  input  logic           out_stall,
  input  logic           div_done,
  output dmac_pkg::cmd_t cmd
);
  import dmac_pkg::*;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_SUM,
    ST_START_S,
    ST_WAIT_S,
    ST_START_L,
    ST_WAIT_L,
    ST_DIFF,
    ST_MUL,
    ST_CHECK,
    ST_WAIT_X,
    ST_FINISH
  } state_t;

  state_t state_r, state_nxt;
  logic   out_valid_r, out_valid_nxt;
  logic   out_free;

  assign out_free = !out_valid_r || !out_stall;

  always_comb begin
    state_nxt     = state_r;
    out_valid_nxt = out_valid_r && out_stall;
    cmd           = '0;
    cmd.div_sel   = SEL_SHORT;
    case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          cmd.accept = 1'b1;
          state_nxt  = ST_SUM;
        end
      end
      ST_SUM: begin
        cmd.sum_upd = 1'b1;
        state_nxt   = ST_START_S;
      end
      ST_START_S: begin
        cmd.div_start = 1'b1;
        state_nxt     = ST_WAIT_S;
      end
      ST_WAIT_S: begin
        if (div_done) begin
          cmd.cap_s = 1'b1;
          state_nxt = ST_START_L;
        end
      end
      ST_START_L: begin
        cmd.div_sel   = SEL_LONG;
        cmd.div_start = 1'b1;
        state_nxt     = ST_WAIT_L;
      end
      ST_WAIT_L: begin
        cmd.div_sel = SEL_LONG;
        if (div_done) begin
          cmd.cap_l = 1'b1;
          state_nxt = ST_DIFF;
        end
      end
      ST_DIFF: begin
        cmd.diff  = 1'b1;
        state_nxt = ST_MUL;
      end
      ST_MUL: begin
        cmd.mul   = 1'b1;
        state_nxt = ST_CHECK;
      end
      ST_CHECK: begin
        cmd.div_sel   = SEL_CROSS;
        cmd.check     = 1'b1;
        cmd.div_start = 1'b1;
        state_nxt     = ST_WAIT_X;
      end
      ST_WAIT_X: begin
        cmd.div_sel = SEL_CROSS;
        if (div_done) begin
          state_nxt = ST_FINISH;
        end
      end
      ST_FINISH: begin
        cmd.div_sel = SEL_CROSS;
        if (out_free) begin
          cmd.load_out  = 1'b1;
          out_valid_nxt = 1'b1;
          state_nxt     = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign in_stall  = (state_r != ST_IDLE);
  assign out_valid = out_valid_r;

endmodule

[hdl/dual_moving_average_crossover_core.sv]
`timescale 1ns / 1ps
// Dual moving average crossover core: top level.
// Depends on dmac_pkg, dmac_ctrl, dmac_datapath, dmac_div.
//
// Usage:
//   in_valid/in_stall/in_price carry one price beat (unsigned, 8 fraction bits).
//   out_valid/out_stall carry one result beat per price: both averages, the
//   cross code, the interpolated crossing level and the ready flag.
//   cfg_valid/cfg_ready/cfg_index/cfg_data write window_short (index 0) or
//   window_long (index 1); either write restarts the sample stream. Other
//   indexes are dropped. cfg_ready is always high; write only while idle.
// Sequence:
//   A price is worked on from acceptance to out_valid, and in_stall holds off the
//   next price until the core is idle again. Most of it is the shared divider at
//   two quotient bits per cycle: once per average, once for the crossing level.
// Reset (rst_n low, synchronous): windows return to 13 and 30, stream state
//   clears, no result is pending. The price ring needs no clearing.
// Stall: a held result stays in the output register; the next price may be
//   accepted and worked on, and waits at the end until the register frees.
module dual_moving_average_crossover_core (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_valid,
  output logic                            in_stall,
  input  logic [dmac_pkg::PRICE_W-1:0]    in_price,
  output logic                            out_valid,
  input  logic                            out_stall,
  output logic [dmac_pkg::PRICE_W-1:0]    out_ma_short,
  output logic [dmac_pkg::PRICE_W-1:0]    out_ma_long,
  output logic [1:0]                      out_cross_code,
  output logic [dmac_pkg::PRICE_W-1:0]    out_cross_level,
  output logic                            out_ready_res,
  input  logic                            cfg_valid,
  output logic                            cfg_ready,
  input  logic [dmac_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [dmac_pkg::WIN_W-1:0]      cfg_data
);
  import dmac_pkg::*;

  cmd_t cmd;
  logic div_done;

  assign cfg_ready = 1'b1;

  dmac_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .div_done  (div_done),
    .cmd       (cmd)
  );

  dmac_datapath u_dp (
    .clk             (clk),
    .rst_n           (rst_n),
    .cmd             (cmd),
    .div_done        (div_done),
    .in_price        (in_price),
    .cfg_we          (cfg_valid && cfg_ready),
    .cfg_index       (cfg_index),
    .cfg_data        (cfg_data),
    .out_ma_short    (out_ma_short),
    .out_ma_long     (out_ma_long),
    .out_cross_code  (out_cross_code),
    .out_cross_level (out_cross_level),
    .out_ready_res   (out_ready_res)
  );

endmodule
